@@ src/bbox_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounding box package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package bbox_pkg;

    localparam int CHAN_W = 8;
    localparam int SIZE_W = 13;
    localparam int POS_W = 12;
    localparam int CFG_IDX_W = 2;

    // Largest size that a 13-bit register can express.
    localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;
    localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_LEVEL_THRESHOLD = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0] col_last;
        logic [SIZE_W-1:0] row_last;
        logic [CHAN_W-1:0] threshold;
    } cfg_t;

endpackage

@@ src/bbox_if.sv @@
// ----------------------------------------------------------------------------
// Bounding box channel interfaces
// Valid/ready channels for pixels, box results and register writes.
// ----------------------------------------------------------------------------
interface bbox_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [bbox_pkg::CHAN_W-1:0]   blue;
    logic [bbox_pkg::CHAN_W-1:0]   green;
    logic [bbox_pkg::CHAN_W-1:0]   red;
    logic [bbox_pkg::CHAN_W-1:0]   alpha;

    modport source (output valid, blue, green, red, alpha, input ready);
    modport sink (input valid, blue, green, red, alpha, output ready);
endinterface

interface bbox_box_if;
    logic                          valid;
    logic                          ready;
    logic [bbox_pkg::POS_W-1:0]    box_x;
    logic [bbox_pkg::POS_W-1:0]    box_y;
    logic [bbox_pkg::SIZE_W-1:0]   box_w;
    logic [bbox_pkg::SIZE_W-1:0]   box_h;
    logic                          found;

    modport source (output valid, box_x, box_y, box_w, box_h, found, input ready);
    modport sink (input valid, box_x, box_y, box_w, box_h, found, output ready);
endinterface

interface bbox_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bbox_pkg::CFG_IDX_W-1:0] index;
    logic [bbox_pkg::SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/bbox_cfg.sv @@
// ----------------------------------------------------------------------------
// Bounding box configuration registers
// Holds frame size and threshold, and derives the clamped last column and row.
// ----------------------------------------------------------------------------
module bbox_cfg #(
    parameter int MAX_WIDTH = bbox_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbox_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bbox_cfg_if.sink          cfg,
    output bbox_pkg::cfg_t    frame_cfg
);

    logic [bbox_pkg::SIZE_W-1:0] width_reg;
    logic [bbox_pkg::SIZE_W-1:0] height_reg;
    logic [bbox_pkg::CHAN_W-1:0] threshold_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= bbox_pkg::WIDTH_RESET;
            height_reg <= bbox_pkg::HEIGHT_RESET;
            threshold_reg <= bbox_pkg::THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (bbox_pkg::reg_index_t'(cfg.index))
                bbox_pkg::REG_FRAME_WIDTH:     width_reg <= cfg.data;
                bbox_pkg::REG_FRAME_HEIGHT:    height_reg <= cfg.data;
                bbox_pkg::REG_LEVEL_THRESHOLD:
                    threshold_reg <= cfg.data[bbox_pkg::CHAN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A size of zero acts as one; a size above the maximum acts as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            frame_cfg.col_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            frame_cfg.col_last = bbox_pkg::SIZE_W'(MAX_WIDTH - 1);
        else
            frame_cfg.col_last = width_reg - 1'b1;

        if (height_reg == '0)
            frame_cfg.row_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            frame_cfg.row_last = bbox_pkg::SIZE_W'(MAX_HEIGHT - 1);
        else
            frame_cfg.row_last = height_reg - 1'b1;

        frame_cfg.threshold = threshold_reg;
    end

endmodule

@@ src/bbox_track.sv @@
// ----------------------------------------------------------------------------
// Bounding box tracker
// Input register, position counters, extent trackers and result register.
// ----------------------------------------------------------------------------
module bbox_track #(
    parameter int MAX_WIDTH = bbox_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbox_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bbox_pkg::cfg_t    frame_cfg,
    bbox_pixel_if.sink        pixel,
    bbox_box_if.source        box
);

    localparam int COL_LIMIT = (MAX_WIDTH > bbox_pkg::SIZE_FIELD_MAX) ?
                               bbox_pkg::SIZE_FIELD_MAX : MAX_WIDTH;
    localparam int ROW_LIMIT = (MAX_HEIGHT > bbox_pkg::SIZE_FIELD_MAX) ?
                               bbox_pkg::SIZE_FIELD_MAX : MAX_HEIGHT;
    localparam int COL_W = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
    localparam int ROW_W = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;

    logic             stage_valid_reg;
    logic             visible_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] min_col_reg;
    logic [COL_W-1:0] min_col_next;
    logic [COL_W-1:0] max_col_reg;
    logic [COL_W-1:0] max_col_next;
    logic [ROW_W-1:0] min_row_reg;
    logic [ROW_W-1:0] min_row_next;
    logic [ROW_W-1:0] max_row_reg;
    logic [ROW_W-1:0] max_row_next;
    logic             seen_reg;
    logic             seen_next;
    logic             out_valid_reg;

    logic [bbox_pkg::POS_W-1:0]  box_x_reg;
    logic [bbox_pkg::POS_W-1:0]  box_y_reg;
    logic [bbox_pkg::SIZE_W-1:0] box_w_reg;
    logic [bbox_pkg::SIZE_W-1:0] box_h_reg;
    logic                        found_reg;

    logic visible;
    logic row_end;
    logic frame_end;
    logic emit;
    logic advance;

    assign visible = (pixel.blue > frame_cfg.threshold) ||
                     (pixel.green > frame_cfg.threshold) ||
                     (pixel.red > frame_cfg.threshold) ||
                     (pixel.alpha > frame_cfg.threshold);

    assign row_end = bbox_pkg::SIZE_W'(col_reg) >= frame_cfg.col_last;
    assign frame_end = bbox_pkg::SIZE_W'(row_reg) >= frame_cfg.row_last;
    assign emit = row_end && frame_end;

    // The pixel held in the input register moves on unless it closes a frame
    // while the previous result is still waiting.
    assign advance = stage_valid_reg && (!emit || !out_valid_reg || box.ready);
    assign pixel.ready = !stage_valid_reg || advance;

    always_comb
    begin
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        if (visible_reg)
        begin
            if (!seen_reg || col_reg < min_col_reg)
                min_col_next = col_reg;
            if (!seen_reg || col_reg > max_col_reg)
                max_col_next = col_reg;
            if (!seen_reg || row_reg < min_row_reg)
                min_row_next = row_reg;
            if (!seen_reg || row_reg > max_row_reg)
                max_row_next = row_reg;
        end
        seen_next = seen_reg || visible_reg;

        col_next = row_end ? '0 : col_reg + 1'b1;
        row_next = row_reg;
        if (row_end)
            row_next = frame_end ? '0 : row_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel.ready)
                stage_valid_reg <= pixel.valid;

            if (advance)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                seen_reg <= emit ? 1'b0 : seen_next;
            end

            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (box.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.ready && pixel.valid)
            visible_reg <= visible;

        if (advance)
        begin
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
        end

        if (advance && emit)
        begin
            if (seen_next)
            begin
                box_x_reg <= bbox_pkg::POS_W'(min_col_next);
                box_y_reg <= bbox_pkg::POS_W'(min_row_next);
                box_w_reg <= bbox_pkg::SIZE_W'({1'b0, max_col_next} -
                                               {1'b0, min_col_next} + 1'b1);
                box_h_reg <= bbox_pkg::SIZE_W'({1'b0, max_row_next} -
                                               {1'b0, min_row_next} + 1'b1);
                found_reg <= 1'b1;
            end
            else
            begin
                box_x_reg <= '0;
                box_y_reg <= '0;
                box_w_reg <= '0;
                box_h_reg <= '0;
                found_reg <= 1'b0;
            end
        end
    end

    assign box.valid = out_valid_reg;
    assign box.box_x = box_x_reg;
    assign box.box_y = box_y_reg;
    assign box.box_w = box_w_reg;
    assign box.box_h = box_h_reg;
    assign box.found = found_reg;

endmodule

@@ src/pixel_bounding_box.sv @@
// Output: a frame's last pixel passes the input register, and its box request is then held in the result register.
// Throughput: one pixel per cycle; the input stalls only when a frame ends while the
// previous frame's box request is still waiting on the output register.
// Reset: position counters and the seen flag clear, and the registers return to
// width 1920, height 1080 and threshold 2.
// ----------------------------------------------------------------------------
// Pixel bounding box
// Finds the tight box around the visible pixels of each raster-order frame.
// ----------------------------------------------------------------------------
module pixel_bounding_box #(
    parameter int MAX_WIDTH = bbox_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbox_pkg::MAX_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bbox_pixel_if.sink    pixel,
    bbox_box_if.source    box,
    bbox_cfg_if.sink      cfg
);

    bbox_pkg::cfg_t cfg_bus;

    bbox_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .frame_cfg (cfg_bus)
    );

    bbox_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_cfg (cfg_bus),
        .pixel     (pixel),
        .box       (box)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel bounding box testbench
// Streams BGRA frames into the block in bursts and predicts the box of each
// frame from its own raster tracker. Every box request is checked field by
// field against the oldest prediction. Register writes fall between phases,
// some of them in the middle of a frame, and cover zero, oversized and
// masked values. The box receiver stalls on a pattern of its own and holds
// off once for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [bbox_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [bbox_pkg::CHAN_W-1:0] blue;
        logic [bbox_pkg::CHAN_W-1:0] green;
        logic [bbox_pkg::CHAN_W-1:0] red;
        logic [bbox_pkg::CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [bbox_pkg::POS_W-1:0]  box_x;
        logic [bbox_pkg::POS_W-1:0]  box_y;
        logic [bbox_pkg::SIZE_W-1:0] box_w;
        logic [bbox_pkg::SIZE_W-1:0] box_h;
        logic                        found;
    } box_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE
    } rx_mode_t;

    logic clk;
    logic rst_n;

    bbox_pixel_if pixel_ch ();
    bbox_box_if   box_ch ();
    bbox_cfg_if   cfg_ch ();

    pixel_bounding_box dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .box   (box_ch),
        .cfg   (cfg_ch)
    );

    pixel_t pixels_to_send[$];
    box_t   pending_boxes[$];

    logic [bbox_pkg::SIZE_W-1:0] cfg_cols;
    logic [bbox_pkg::SIZE_W-1:0] cfg_rows;
    logic [bbox_pkg::CHAN_W-1:0] cfg_level;

    logic [bbox_pkg::POS_W-1:0]  at_col;
    logic [bbox_pkg::POS_W-1:0]  at_row;
    logic [bbox_pkg::SIZE_W-1:0] left_col;
    logic [bbox_pkg::SIZE_W-1:0] top_row;
    logic [bbox_pkg::POS_W-1:0]  right_col;
    logic [bbox_pkg::POS_W-1:0]  bottom_row;
    logic                        any_lit;

    int       error_count = 0;
    int       boxes_seen = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    logic     hold_active = 1'b0;
    logic     random_part = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [bbox_pkg::SIZE_W-1:0] clamp_size(
        logic [bbox_pkg::SIZE_W-1:0] v, int limit);
        if (v == '0)
            return bbox_pkg::SIZE_W'(1);
        if (v > limit)
            return bbox_pkg::SIZE_W'(limit);
        return v;
    endfunction

    function automatic void clear_tracker();
        at_col = '0;
        at_row = '0;
        left_col = '1;
        top_row = '1;
        right_col = '0;
        bottom_row = '0;
        any_lit = 1'b0;
    endfunction

    function automatic void track_pixel(pixel_t px);
        logic [bbox_pkg::SIZE_W-1:0] cols;
        logic [bbox_pkg::SIZE_W-1:0] rows;
        logic                        lit;
        box_t                        box;
        cols = clamp_size(cfg_cols, bbox_pkg::MAX_WIDTH_DEF);
        rows = clamp_size(cfg_rows, bbox_pkg::MAX_HEIGHT_DEF);
        lit = (px.blue > cfg_level) || (px.green > cfg_level)
            || (px.red > cfg_level) || (px.alpha > cfg_level);
        if (lit)
        begin
            if (!any_lit || at_col < left_col)
                left_col = bbox_pkg::SIZE_W'(at_col);
            if (!any_lit || at_col > right_col)
                right_col = at_col;
            if (!any_lit || at_row < top_row)
                top_row = bbox_pkg::SIZE_W'(at_row);
            if (!any_lit || at_row > bottom_row)
                bottom_row = at_row;
            any_lit = 1'b1;
        end
        if (at_col < cols - 1)
        begin
            at_col = at_col + 1'b1;
            return;
        end
        at_col = '0;
        if (at_row < rows - 1)
        begin
            at_row = at_row + 1'b1;
            return;
        end
        box = '0;
        if (any_lit)
        begin
            box.box_x = left_col[bbox_pkg::POS_W-1:0];
            box.box_y = top_row[bbox_pkg::POS_W-1:0];
            box.box_w = bbox_pkg::SIZE_W'(right_col) - left_col + 1'b1;
            box.box_h = bbox_pkg::SIZE_W'(bottom_row) - top_row + 1'b1;
            box.found = 1'b1;
        end
        pending_boxes.push_back(box);
        clear_tracker();
    endfunction

    function automatic pixel_t make_pixel(bit lit);
        pixel_t px;
        px.blue = 8'($urandom_range(cfg_level, 0));
        px.green = 8'($urandom_range(cfg_level, 0));
        px.red = 8'($urandom_range(cfg_level, 0));
        px.alpha = 8'($urandom_range(cfg_level, 0));
        if (lit && cfg_level != 8'hFF)
        begin
            case ($urandom_range(4, 0))
                0: px.blue = 8'($urandom_range(255, int'(cfg_level) + 1));
                1: px.green = 8'($urandom_range(255, int'(cfg_level) + 1));
                2: px.red = 8'($urandom_range(255, int'(cfg_level) + 1));
                3: px.alpha = 8'($urandom_range(255, int'(cfg_level) + 1));
                default: px = $urandom | {4{cfg_level + 8'd1}};
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(int b, int g, int r, int a);
        pixels_to_send.push_back({8'(b), 8'(g), 8'(r), 8'(a)});
    endtask

    // A run of dark pixels with at most two lit ones at the given offsets.
    task automatic queue_run(int count, int hot_a, int hot_b);
        for (int i = 0; i < count; i++)
            pixels_to_send.push_back(make_pixel(i == hot_a || i == hot_b));
    endtask

    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || pixel_ch.valid || pending_boxes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [bbox_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bbox_pkg::SIZE_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            bbox_pkg::REG_FRAME_WIDTH:     cfg_cols = value;
            bbox_pkg::REG_FRAME_HEIGHT:    cfg_rows = value;
            bbox_pkg::REG_LEVEL_THRESHOLD: cfg_level = value[bbox_pkg::CHAN_W-1:0];
            default:                       ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Pixel sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t next_px;
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
            pixel_ch.blue <= '0;
            pixel_ch.green <= '0;
            pixel_ch.red <= '0;
            pixel_ch.alpha <= '0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                track_pixel({pixel_ch.blue, pixel_ch.green, pixel_ch.red, pixel_ch.alpha});
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (gap_left > 0 || pixels_to_send.size() == 0)
                begin
                    pixel_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    next_px = pixels_to_send.pop_front();
                    pixel_ch.valid <= 1'b1;
                    pixel_ch.blue <= next_px.blue;
                    pixel_ch.green <= next_px.green;
                    pixel_ch.red <= next_px.red;
                    pixel_ch.alpha <= next_px.alpha;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
            end
        end
    end

    // Box receiver: checks each request and stalls on a pattern of its own.
    always @(posedge clk or negedge rst_n)
    begin
        box_t got;
        box_t want;
        logic rdy;
        if (!rst_n)
        begin
            box_ch.ready <= 1'b0;
        end
        else
        begin
            if (box_ch.valid && box_ch.ready)
            begin
                got = {box_ch.box_x, box_ch.box_y, box_ch.box_w, box_ch.box_h, box_ch.found};
                boxes_seen++;
                if (pending_boxes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected box request: x=%0d y=%0d w=%0d h=%0d found=%0b",
                                 got.box_x, got.box_y, got.box_w, got.box_h, got.found);
                end
                else
                begin
                    want = pending_boxes.pop_front();
                    if (got.box_x !== want.box_x || got.box_y !== want.box_y
                        || got.box_w !== want.box_w || got.box_h !== want.box_h
                        || got.found !== want.found)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"Box mismatch: expected x=%0d y=%0d w=%0d h=%0d ",
                                      "found=%0b, got x=%0d y=%0d w=%0d h=%0d found=%0b"},
                                     want.box_x, want.box_y, want.box_w, want.box_h,
                                     want.found, got.box_x, got.box_y, got.box_w,
                                     got.box_h, got.found);
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_left = $urandom_range(200, 20);
                rx_mode = rx_mode_t'($urandom_range(2, 0));
            end
            else
            begin
                rx_left--;
            end
            case (rx_mode)
                RX_ALWAYS: rdy = 1'b1;
                RX_HALF:   rdy = ($urandom_range(1, 0) == 1);
                default:   rdy = ($urandom_range(4, 0) == 0);
            endcase
            box_ch.ready <= rdy && !hold_active;
        end
    end

    // Long hold-off on the box side while pixels keep coming.
    initial
    begin
        wait (random_part);
        repeat (50) @(posedge clk);
        hold_active <= 1'b1;
        repeat (600) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        int sent;
        int cols;
        int rows;
        int frames;
        int pct;
        int count;
        int lvl;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cfg_cols = bbox_pkg::WIDTH_RESET;
        cfg_rows = bbox_pkg::HEIGHT_RESET;
        cfg_level = bbox_pkg::THRESHOLD_RESET;
        clear_tracker();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Start of a full-size frame, then shrink the frame under it.
        push_pixel(0, 0, 0, 2);
        push_pixel(0, 0, 0, 3);
        push_pixel(2, 2, 2, 2);
        push_pixel(0, 0, 0, 0);
        push_pixel(255, 255, 255, 255);
        wait_idle();
        write_register(bbox_pkg::REG_FRAME_HEIGHT, 13'd2);
        write_register(bbox_pkg::REG_FRAME_WIDTH, 13'd3);
        push_pixel(0, 0, 0, 0);
        push_pixel(0, 3, 0, 0);
        push_pixel(0, 0, 0, 0);
        push_pixel(0, 0, 0, 0);
        wait_idle();

        // Zero sizes give one-pixel frames; each channel alone lights a pixel.
        write_register(bbox_pkg::REG_FRAME_WIDTH, 13'd0);
        write_register(bbox_pkg::REG_FRAME_HEIGHT, 13'd0);
        push_pixel(3, 0, 0, 0);
        push_pixel(0, 3, 0, 0);
        push_pixel(0, 0, 3, 0);
        push_pixel(0, 0, 0, 3);
        push_pixel(2, 2, 2, 2);
        push_pixel(0, 0, 0, 0);
        wait_idle();
        write_register(bbox_pkg::REG_LEVEL_THRESHOLD, 13'h1F00);
        push_pixel(0, 0, 0, 1);
        push_pixel(0, 0, 0, 0);
        push_pixel(1, 0, 0, 0);
        wait_idle();
        write_register(bbox_pkg::REG_LEVEL_THRESHOLD, 13'h00FF);
        push_pixel(255, 255, 255, 255);
        wait_idle();
        write_register(REG_UNUSED, 13'h0001);
        push_pixel(255, 255, 255, 255);
        wait_idle();

        // Oversized sizes, then a smaller size that closes the row or frame at once.
        write_register(bbox_pkg::REG_LEVEL_THRESHOLD, 13'd2);
        write_register(bbox_pkg::REG_FRAME_WIDTH, 13'h1FFF);
        write_register(bbox_pkg::REG_FRAME_HEIGHT, 13'd1);
        queue_run(40, 5, 30);
        wait_idle();
        write_register(bbox_pkg::REG_FRAME_WIDTH, 13'd8);
        queue_run(1, -1, -1);
        wait_idle();
        write_register(bbox_pkg::REG_FRAME_WIDTH, 13'd2);
        write_register(bbox_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
        queue_run(20, 3, 16);
        wait_idle();
        write_register(bbox_pkg::REG_FRAME_HEIGHT, 13'd3);
        queue_run(2, -1, -1);
        wait_idle();

        random_part = 1'b1;
        sent = 0;
        while (sent < 720)
        begin
            if ($urandom_range(3, 0) != 0)
                write_register(bbox_pkg::REG_FRAME_WIDTH, ($urandom_range(9, 0) == 0)
                               ? 13'd0 : 13'($urandom_range(24, 1)));
            if ($urandom_range(3, 0) != 0)
                write_register(bbox_pkg::REG_FRAME_HEIGHT, ($urandom_range(9, 0) == 0)
                               ? 13'd0 : 13'($urandom_range(5, 1)));
            if ($urandom_range(2, 0) == 0)
            begin
                case ($urandom_range(7, 0))
                    0:       lvl = 0;
                    1:       lvl = 255;
                    default: lvl = $urandom_range(254, 1);
                endcase
                write_register(bbox_pkg::REG_LEVEL_THRESHOLD, {5'($urandom), 8'(lvl)});
            end
            if ($urandom_range(9, 0) == 0)
                write_register(REG_UNUSED, 13'($urandom));
            cols = int'(clamp_size(cfg_cols, bbox_pkg::MAX_WIDTH_DEF));
            rows = int'(clamp_size(cfg_rows, bbox_pkg::MAX_HEIGHT_DEF));
            frames = $urandom_range(4, 1);
            count = frames * cols * rows;
            if ($urandom_range(3, 0) == 0)
                count += $urandom_range(cols * rows - 1, 0);
            for (int f = 0; f < count; f++)
            begin
                if (f % (cols * rows) == 0)
                begin
                    case ($urandom_range(3, 0))
                        0:       pct = 0;
                        1:       pct = 10;
                        2:       pct = 50;
                        default: pct = 90;
                    endcase
                end
                if ($urandom_range(9, 0) == 0)
                    pixels_to_send.push_back(pixel_t'($urandom));
                else
                    pixels_to_send.push_back(make_pixel($urandom_range(99, 0) < pct));
            end
            sent += count;
            wait_idle();
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (pending_boxes.size() != 0)
        begin
            error_count++;
            $display("%0d box requests never arrived", pending_boxes.size());
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
src/bbox_pkg.sv
src/bbox_if.sv
src/bbox_cfg.sv
src/bbox_track.sv
src/pixel_bounding_box.sv
tb/testbench.sv
